### sv/roman_numeral_encoder_defines.svh
// assertion macros shared by the roman numeral encoder modules
// the modules that use them provide clk and rst_n
`ifndef ROMAN_NUMERAL_ENCODER_DEFINES_SVH
`define ROMAN_NUMERAL_ENCODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RNE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RNE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RNE_ASSERT_IMP(lbl, ante, cons, msg)
`define RNE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### sv/rne_pkg.sv
`default_nettype none

package rne_pkg;

  localparam int VALUE_W   = 12;
  localparam int SYMBOL_W  = 7;
  localparam int NUM_TOKENS = 13;
  localparam int TOK_IW    = 4;

  localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

  localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
  localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4D;
  localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
  localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
  localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4C;
  localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
  localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
  localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;

  // greedy token table, largest first
  localparam logic [VALUE_W-1:0] TOK_VALUE [NUM_TOKENS] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam logic [SYMBOL_W-1:0] TOK_FIRST [NUM_TOKENS] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };
  localparam logic [SYMBOL_W-1:0] TOK_SECOND [NUM_TOKENS] = '{
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
    CH_X, CH_NONE, CH_V, CH_NONE
  };

  // one queued job between front and back
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               oor;
  } rne_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rne_qstat_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } rne_bk_state_t;

  // index of the largest token not above rem
  function automatic logic [TOK_IW-1:0] tok_pick(input logic [VALUE_W-1:0] rem);
    logic [TOK_IW-1:0] idx;
    idx = TOK_IW'(NUM_TOKENS - 1);
    for (int i = NUM_TOKENS - 1; i >= 0; i--) begin
      if (rem >= TOK_VALUE[i]) idx = TOK_IW'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### sv/rne_front.sv
`default_nettype none

module rne_front
  import rne_pkg::*;
(
  input  wire logic               in_valid,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    in_stall,
  input  wire rne_qstat_t         q_stat,
  output logic                    push,
  output rne_job_t                job
);

  // zero is taken and dropped, it has no characters
  assign in_stall  = q_stat.full;
  assign push      = in_valid && !q_stat.full && (in_value != '0);
  assign job.value = in_value;
  assign job.oor   = (in_value > MAX_VALID);

endmodule

`default_nettype wire

### sv/rne_queue.sv
`default_nettype none
`include "roman_numeral_encoder_defines.svh"

module rne_queue
  import rne_pkg::*;
#(
  parameter int Q_DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire rne_job_t push_job,
  input  wire logic     pop,
  output rne_job_t      pop_job,
  output rne_qstat_t    q_stat
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  rne_job_t         slot_r [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_job      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  `RNE_ASSERT_IMP(a_q_no_overflow, push, !q_stat.full, "queue push while full")
  `RNE_ASSERT_IMP(a_q_no_underflow, pop, !q_stat.empty, "queue pop while empty")
  `RNE_ASSERT_NXT(a_q_push_only_fills, push && !pop, !q_stat.empty,
                  "queue empty after push")

endmodule

`default_nettype wire

### sv/rne_back.sv
`default_nettype none
`include "roman_numeral_encoder_defines.svh"

module rne_back
  import rne_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rne_qstat_t          q_stat,
  input  wire rne_job_t            job,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SYMBOL_W-1:0]      out_symbol,
  output logic                     out_last,
  output logic                     out_out_of_range
);

  rne_bk_state_t         state_r, state_nxt;
  logic [VALUE_W-1:0]    rem_r, rem_nxt;
  logic [SYMBOL_W-1:0]   pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SYMBOL_W-1:0]   out_symbol_r, out_symbol_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_oor_r, out_oor_nxt;

  logic                  ld_ok;
  logic                  emit_last;
  logic [TOK_IW-1:0]     tok_idx;
  logic [VALUE_W-1:0]    rem_sub;

  assign ld_ok   = !out_valid_r || !out_stall;
  assign tok_idx = tok_pick(rem_r);
  assign rem_sub = rem_r - TOK_VALUE[tok_idx];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop && !job.oor) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (ld_ok && emit_last) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    pop            = 1'b0;
    emit_last      = 1'b0;
    rem_nxt        = rem_r;
    pend_nxt       = pend_r;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_oor_nxt    = out_oor_r;
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      BK_IDLE: begin
        pop = !q_stat.empty && ld_ok;
        if (pop) begin
          if (job.oor) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = CH_NONE;
            out_last_nxt   = 1'b1;
            out_oor_nxt    = 1'b1;
          end else begin
            rem_nxt  = job.value;
            pend_nxt = CH_NONE;
          end
        end
      end
      BK_EMIT: begin
        if (pend_r != CH_NONE) begin
          emit_last = (rem_r == '0);
          if (ld_ok) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = pend_r;
            out_last_nxt   = emit_last;
            out_oor_nxt    = 1'b0;
            pend_nxt       = CH_NONE;
          end
        end else begin
          emit_last = (TOK_SECOND[tok_idx] == CH_NONE) && (rem_sub == '0);
          if (ld_ok) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = TOK_FIRST[tok_idx];
            out_last_nxt   = emit_last;
            out_oor_nxt    = 1'b0;
            pend_nxt       = TOK_SECOND[tok_idx];
            rem_nxt        = rem_sub;
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rem_r       <= '0;
      pend_r      <= CH_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_oor_r    <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_last         = out_last_r;
  assign out_out_of_range = out_oor_r;

  `RNE_ASSERT_IMP(a_bk_oor_single, out_valid_r && out_oor_r,
                  out_last_r && (out_symbol_r == CH_NONE), "bad out-of-range result")
  `RNE_ASSERT_IMP(a_bk_emit_has_work, state_r == BK_EMIT,
                  (pend_r != CH_NONE) || (rem_r != '0), "emit state with nothing left")
  `RNE_ASSERT_IMP(a_bk_idle_no_pending, state_r == BK_IDLE, pend_r == CH_NONE,
                  "second letter left behind")

endmodule

`default_nettype wire

### sv/roman_numeral_encoder.sv
`default_nettype none

// roman numeral encoder: takes a 12-bit unsigned value and streams its
// standard roman numeral as 7-bit ascii, one character per output item,
// with out_last on the final character. greedy largest-first over
// M CM D CD C XC L XL X IX V IV I. a value of 0 is accepted and gives no
// output; 4000..4095 give one item with symbol 0, out_last and
// out_out_of_range set. a front stage classifies each input item and
// drops zeros, a small job queue (Q_DEPTH entries) decouples it from the
// back sequencer, which writes one character per cycle into the output
// register while the receiver does not stall. the back sequencer picks up
// a job while idle, then writes its characters one by one, and takes
// the next job only after the last one; the 15-character worst case is
// 3888. an out-of-range item is written at pickup. the input accepts
// while the queue has room
module roman_numeral_encoder
  import rne_pkg::*;
#(
  parameter int Q_DEPTH = 2   // job queue entries, 2 or more
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  input  wire logic [VALUE_W-1:0]  in_value,
  output logic                     in_stall,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SYMBOL_W-1:0]      out_symbol,
  output logic                     out_last,
  output logic                     out_out_of_range
);

  rne_qstat_t q_stat;
  logic       push;
  logic       pop;
  rne_job_t   push_job;
  rne_job_t   pop_job;

  // front: classify and drop zeros
  rne_front u_front (
    .in_valid (in_valid),
    .in_value (in_value),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  // job queue between the two halves
  rne_queue #(
    .Q_DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // back: character sequencer with registered output
  rne_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .job              (pop_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule

`default_nettype wire

### bench/roman_numeral_encoder_test.sv
`default_nettype none

// testbench for the roman numeral encoder
// every accepted value is spelled digit by digit on the bench side and the
// expected characters are queued; each character leaving the block is
// compared field by field against the head of that queue
module roman_numeral_encoder_test;
  import rne_pkg::*;

  localparam int RANDOM_ITEMS = 180;   // nonzero values in the random part
  localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 40;    // well past the longest numeral

  // one value per greedy token, largest first
  localparam int TOKEN_VALUES [13] = '{
    1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
  };

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                out_of_range;
  } numeral_char_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,      // never stalls
    RX_RANDOM,    // coin flip every cycle
    RX_RUNS,      // long runs of stall and no stall
    RX_PERIODIC   // fixed duty cycle from a free counter
  } rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SYMBOL_W-1:0] out_symbol;
  logic                out_last;
  logic                out_out_of_range;

  // characters still owed by the block, oldest first
  numeral_char_t       pending_chars [$];
  // scratch for one numeral while it is being spelled
  logic [SYMBOL_W-1:0] letters [$];
  numeral_char_t       want;

  int mismatches    = 0;
  int chars_checked = 0;
  int items_sent    = 0;
  int zeros_sent    = 0;
  int oor_sent      = 0;
  int burst_left    = 0;
  int quiet_cycles  = 0;

  rx_mode_t   rx_mode      = RX_OPEN;
  int         rx_mode_left = 0;
  logic [2:0] rx_phase     = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  roman_numeral_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_value         (in_value),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // one decimal digit in roman form: one, five and ten are the letters of
  // that decade; 4 and 9 are the subtractive pairs
  function automatic void spell_digit(input int d, input logic [SYMBOL_W-1:0] one,
                                      input logic [SYMBOL_W-1:0] five,
                                      input logic [SYMBOL_W-1:0] ten);
    if (d == 9) begin
      letters.push_back(one);
      letters.push_back(ten);
    end else if (d == 4) begin
      letters.push_back(one);
      letters.push_back(five);
    end else begin
      if (d >= 5) letters.push_back(five);
      for (int i = 0; i < d % 5; i++) letters.push_back(one);
    end
  endfunction

  // queue the characters that one accepted value must produce
  function automatic void spell_numeral(input logic [VALUE_W-1:0] v);
    int n;
    numeral_char_t c;
    n = v;
    letters.delete();
    if (n > MAX_VALID) begin
      // out of range: a single flagged item with no letter
      c.symbol       = CH_NONE;
      c.last         = 1'b1;
      c.out_of_range = 1'b1;
      pending_chars.push_back(c);
    end else if (n != 0) begin
      // thousands never go past 3, so M repeats with no five or ten
      for (int i = 0; i < n / 1000; i++) letters.push_back(CH_M);
      spell_digit((n / 100) % 10, CH_C, CH_D, CH_M);
      spell_digit((n / 10) % 10, CH_X, CH_L, CH_C);
      spell_digit(n % 10, CH_I, CH_V, CH_X);
      foreach (letters[i]) begin
        c.symbol       = letters[i];
        c.last         = (i == letters.size() - 1);
        c.out_of_range = 1'b0;
        pending_chars.push_back(c);
      end
    end
    // zero: nothing at all
  endfunction

  // ---------------------------------------------------------------------
  // monitors and checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatches < 30) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // input side: every accepted value adds its expected characters
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      spell_numeral(in_value);
      items_sent++;
      if (in_value == 0) zeros_sent++;
      if (in_value > MAX_VALID) oor_sent++;
    end
  end

  // output side: each accepted character against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected item symbol=%h last=%b oor=%b",
                                  out_symbol, out_last, out_out_of_range));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_symbol !== want.symbol)
          report_mismatch($sformatf("symbol %h, expected %h", out_symbol, want.symbol));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, expected %b (symbol %h)",
                                    out_last, want.last, want.symbol));
        if (out_out_of_range !== want.out_of_range)
          report_mismatch($sformatf("out_of_range %b, expected %b",
                                    out_out_of_range, want.out_of_range));
      end
    end
  end

  // watchdog: any stretch this long without a handshake means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d characters still owed",
               QUIET_LIMIT, pending_chars.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: switches between stall patterns after a random run, so
  // stalls land on every character position of a numeral
  always @(posedge clk) begin
    rx_phase <= rx_phase + 3'd1;
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 120);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_stall <= 1'b0;
      RX_RANDOM:   out_stall <= 1'($urandom_range(0, 1));
      RX_RUNS:     out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
      RX_PERIODIC: out_stall <= (rx_phase < 3'd3);
      default:     out_stall <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // sender works in bursts: between bursts valid drops for a random gap
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // bounds of the value field, zero alone and in a row, all bits set
  task automatic test_range_edges();
    send_value(12'd0);
    send_value(12'd1);
    send_value(12'd3999);
    send_value(12'd4000);
    send_value(12'd4095);
    send_value(12'd0);
    send_value(12'd0);
  endtask

  // every greedy token on its own, the two-letter ones included
  task automatic test_every_token();
    foreach (TOKEN_VALUES[i]) send_value(VALUE_W'(TOKEN_VALUES[i]));
  endtask

  // 3888 is the longest numeral, fifteen characters back to back
  task automatic test_longest_numeral();
    repeat (3) send_value(12'd3888);
  endtask

  // mostly valid values with random content, some short and long numerals,
  // plus out of range values and zeros as noise
  task automatic test_random_values();
    int counted;
    int pick;
    logic [VALUE_W-1:0] v;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      v = VALUE_W'($urandom_range(1, 3999));
      else if (pick < 70) v = VALUE_W'($urandom_range(1, 60));
      else if (pick < 82) v = VALUE_W'($urandom_range(3000, 3999));
      else if (pick < 91) v = VALUE_W'($urandom_range(4000, 4095));
      else if (pick < 96) v = '0;
      else                v = VALUE_W'($urandom_range(0, 4095));
      send_value(v);
      // zeros are dropped by the block and do not count
      if (v != 0) counted++;
    end
  endtask

  // let the block drain, then give the verdict
  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    // wait DRAIN_CYCLES more so that any stray extra item is caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d values (%0d zero, %0d out of range), %0d characters checked",
             items_sent, zeros_sent, oor_sent, chars_checked);
    $display("sender ran in random bursts, receiver cycled through four stall patterns");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_range_edges();
    test_every_token();
    test_longest_numeral();
    test_random_values();
    finish_run();
  end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/rne_pkg.sv
sv/rne_front.sv
sv/rne_queue.sv
sv/rne_back.sv
sv/roman_numeral_encoder.sv
bench/roman_numeral_encoder_test.sv
